// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page table walker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Types and constants shared by the front end, the walk engine and the top.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int TopAddrW = 19;
   localparam int IndexW   = 10;
   localparam int OffsetW  = 12;

   localparam int BitValid = 0;
   localparam int BitRead  = 2;
   localparam int BitWrite = 3;
   localparam int BitExec  = 4;
   localparam int BitUser  = 5;

   typedef enum logic {
      CMD_WRITE     = 1'b0,
      CMD_TRANSLATE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_ADDR = 2'd1,
      ST_BAD_PERM = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ACC_READ     = 2'd0,
      ACC_WRITE    = 2'd1,
      ACC_FETCH    = 2'd2,
      ACC_RESERVED = 2'd3
   } access_type;

   typedef enum logic [1:0] {
      WS_IDLE = 2'd0,
      WS_TOP  = 2'd1,
      WS_LEAF = 2'd2
   } walk_state_type;

   typedef struct packed {
      cmd_type               cmd;
      logic                  wr_ok;
      logic                  top_ok;
      logic [15:0]           word_index;
      logic [31:0]           word_data;
      logic [TopAddrW-1:0]   top_addr;
      logic [IndexW-1:0]     mid_index;
      logic [OffsetW-1:0]    page_offset;
      access_type            access_kind;
      logic                  user_access;
   } op_type;

endpackage

// File: src/ptw_front.sv
// ----------------------------------------------------------------------------
// Page table walker front end
// Accepts items, decodes them, checks the top-level table address and the
// write word index, then holds them in a two-entry queue for the walk engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptw_front #(
   parameter int PHYS_PAGES = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_cmd,
   input  logic [15:0]     req_word_index,
   input  logic [31:0]     req_word_data,
   input  logic [17:0]     req_table_base,
   input  logic [31:0]     req_virtual_address,
   input  logic [1:0]      req_access_kind,
   input  logic            req_user_access,
   output logic            q_valid,
   output ptw_pkg::op_type q_item,
   input  logic            q_pop
);

   localparam int unsigned MemWords = PHYS_PAGES * 1024;
   localparam int unsigned MemBytes = PHYS_PAGES * 4096;

   ptw_pkg::op_type                  new_item;
   ptw_pkg::op_type                  entry_ff [2];
   logic [ptw_pkg::TopAddrW-1:0]     top_addr;
   logic                             push;
   logic                             wr_ptr_ff, wr_ptr_in;
   logic                             rd_ptr_ff, rd_ptr_in;
   logic [1:0]                       count_ff, count_in;

   always_comb begin
      top_addr = {1'b0, req_table_base}
               + {7'd0, req_virtual_address[31:22], 2'b00};
      new_item.cmd         = ptw_pkg::cmd_type'(req_cmd);
      new_item.wr_ok       = ({16'd0, req_word_index} < 32'(MemWords));
      new_item.top_ok      = ({13'd0, top_addr} < 32'(MemBytes));
      new_item.word_index  = req_word_index;
      new_item.word_data   = req_word_data;
      new_item.top_addr    = top_addr;
      new_item.mid_index   = req_virtual_address[21:12];
      new_item.page_offset = req_virtual_address[11:0];
      new_item.access_kind = ptw_pkg::access_type'(req_access_kind);
      new_item.user_access = req_user_access;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PTW_ASSERT_IMPL(a_pop_needs_item, clock, reset, q_pop, q_valid)
   `PTW_ASSERT_NEXT(a_drain_counts, clock, reset, q_pop && !push, count_ff == $past(count_ff) - 2'd1)

endmodule

// File: src/ptw_back.sv
// ----------------------------------------------------------------------------
// Page table walker engine
// Owns the physical memory, performs writes and two-level walks, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptw_back #(
   parameter int PHYS_PAGES = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  ptw_pkg::op_type q_item,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [31:0]     rsp_physical_address
);

   localparam int unsigned MemWords = PHYS_PAGES * 1024;
   localparam int unsigned MemBytes = PHYS_PAGES * 4096;
   localparam int          AddrW    = $clog2(MemWords);

   logic [31:0]                mem [0:MemWords-1];
   logic [31:0]                rd_data_ff;
   ptw_pkg::walk_state_type    state_ff, state_in;
   ptw_pkg::op_type            cur_ff, cur_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ptw_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [31:0]                rsp_pa_ff, rsp_pa_in;

   logic                       out_free;
   logic [31:0]                leaf_byte;
   logic                       leaf_ok;
   logic                       need_ok;
   logic [31:0]                wr_wide, top_wide, leaf_wide;
   logic                       mem_we;
   logic [AddrW-1:0]           mem_waddr, mem_raddr;
   logic                       res_load;
   ptw_pkg::status_type        res_status;
   logic [31:0]                res_pa;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign leaf_byte = {rd_data_ff[31:12], cur_ff.mid_index, 2'b00};
   assign leaf_ok   = (leaf_byte < 32'(MemBytes));
   assign wr_wide   = {16'd0, q_item.word_index};
   assign top_wide  = {15'd0, q_item.top_addr[ptw_pkg::TopAddrW-1:2]};
   assign leaf_wide = {2'd0, leaf_byte[31:2]};
   assign mem_waddr = wr_wide[AddrW-1:0];

   always_comb begin
      case (cur_ff.access_kind)
         ptw_pkg::ACC_READ:  need_ok = rd_data_ff[ptw_pkg::BitRead];
         ptw_pkg::ACC_WRITE: need_ok = rd_data_ff[ptw_pkg::BitWrite];
         ptw_pkg::ACC_FETCH: need_ok = rd_data_ff[ptw_pkg::BitExec];
         default:            need_ok = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptw_pkg::WS_IDLE: begin
            if (q_valid && out_free && q_item.cmd == ptw_pkg::CMD_TRANSLATE
                && q_item.top_ok) begin
               state_in = ptw_pkg::WS_TOP;
            end
         end
         ptw_pkg::WS_TOP: begin
            if (rd_data_ff[ptw_pkg::BitValid] && leaf_ok) begin
               state_in = ptw_pkg::WS_LEAF;
            end else begin
               state_in = ptw_pkg::WS_IDLE;
            end
         end
         ptw_pkg::WS_LEAF: state_in = ptw_pkg::WS_IDLE;
         default:          state_in = ptw_pkg::WS_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      mem_raddr  = top_wide[AddrW-1:0];
      res_load   = 1'b0;
      res_status = ptw_pkg::ST_OK;
      res_pa     = 32'd0;
      case (state_ff)
         ptw_pkg::WS_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (q_item.cmd == ptw_pkg::CMD_WRITE) begin
                  mem_we   = q_item.wr_ok;
                  res_load = 1'b1;
               end else if (!q_item.top_ok) begin
                  res_load   = 1'b1;
                  res_status = ptw_pkg::ST_BAD_ADDR;
               end
            end
         end
         ptw_pkg::WS_TOP: begin
            mem_raddr = leaf_wide[AddrW-1:0];
            if (!(rd_data_ff[ptw_pkg::BitValid] && leaf_ok)) begin
               res_load   = 1'b1;
               res_status = ptw_pkg::ST_BAD_ADDR;
            end
         end
         ptw_pkg::WS_LEAF: begin
            res_load = 1'b1;
            if (!rd_data_ff[ptw_pkg::BitValid]) begin
               res_status = ptw_pkg::ST_BAD_ADDR;
            end else if (cur_ff.user_access && !rd_data_ff[ptw_pkg::BitUser]) begin
               res_status = ptw_pkg::ST_BAD_PERM;
            end else if (!need_ok) begin
               res_status = ptw_pkg::ST_BAD_PERM;
            end else begin
               res_pa = {rd_data_ff[31:12], cur_ff.page_offset};
            end
         end
         default: begin
            res_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      cur_in        = q_pop ? q_item : cur_ff;
      rsp_valid_in  = res_load || (rsp_valid_ff && rsp_stall);
      rsp_status_in = res_load ? res_status : rsp_status_ff;
      rsp_pa_in     = res_load ? res_pa : rsp_pa_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= q_item.word_data;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pa_ff     <= rsp_pa_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptw_pkg::WS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_physical_address = rsp_pa_ff;

   `PTW_ASSERT_IMPL(a_pop_only_idle, clock, reset, q_pop, state_ff == ptw_pkg::WS_IDLE)
   `PTW_ASSERT_IMPL(a_walk_out_empty, clock, reset, state_ff != ptw_pkg::WS_IDLE, !rsp_valid_ff)
   `PTW_ASSERT_IMPL(a_fault_zero_pa, clock, reset, rsp_valid_ff && rsp_status_ff != ptw_pkg::ST_OK, rsp_pa_ff == 32'd0)
   `PTW_ASSERT_NEXT(a_leaf_ends_walk, clock, reset, state_ff == ptw_pkg::WS_LEAF, state_ff == ptw_pkg::WS_IDLE && rsp_valid_ff)

endmodule

// File: src/two_level_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// Two-level page table walker core
// A write item stores one word of physical memory; a translate item walks
// a 10/10/12 two-level page table and returns a status and physical address.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue, so the request side keeps moving while a
// walk is in progress or a result waits, until the queue is full. The
// engine owns a synchronous memory of PHYS_PAGES*1024 words with one write
// and one read per cycle. A write item is handled in the engine's idle
// state, as is a translate item whose top-level address is outside memory.
// A full translation steps through the top-level read, the dependent
// second-level read and the result, so the memory read and the dependence
// between the two reads set the rate. Walks that fail at the top-level
// entry end in the top state with a bad-address status. Memory contents
// are undefined until written, and there is no clearing pass after reset.

module two_level_page_table_walker_core #(
   parameter int PHYS_PAGES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [15:0] req_word_index,
   input  logic [31:0] req_word_data,
   input  logic [17:0] req_table_base,
   input  logic [31:0] req_virtual_address,
   input  logic [1:0]  req_access_kind,
   input  logic        req_user_access,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_physical_address
);

   logic            q_valid;
   logic            q_pop;
   ptw_pkg::op_type q_item;

   ptw_front #(
      .PHYS_PAGES(PHYS_PAGES)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_word_index      (req_word_index),
      .req_word_data       (req_word_data),
      .req_table_base      (req_table_base),
      .req_virtual_address (req_virtual_address),
      .req_access_kind     (req_access_kind),
      .req_user_access     (req_user_access),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop)
   );

   ptw_back #(
      .PHYS_PAGES(PHYS_PAGES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_physical_address (rsp_physical_address)
   );

endmodule
